// ----- hw/rtl/mpq_pkg.sv -----
// Shared types and constants for the min priority queue.
// Holds command and status codes, controller states and the
// controller/datapath interface structs. No dependencies.
package mpq_pkg;

  localparam int KEY_W      = 32;
  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 2;
  localparam int CNT_OUT_W  = 5;
  localparam int IN_TDATA_W = 32;
  localparam int OUT_TDATA_W = 40;

  // Request commands
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK   = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_FINISH
  } mpq_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_in;
    logic decode;
    logic scan_step;
    logic load_out;
  } mpq_ctrl_t;

  // Datapath to controller
  typedef struct packed {
    logic need_scan;
    logic scan_last;
    logic out_free;
  } mpq_stat_t;

endpackage

// ----- hw/rtl/mpq_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port,
// registered read data. No dependencies.
module mpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/mpq_ctrl.sv -----
// Controller state machine for the min priority queue.
// Depends on mpq_pkg for states and interface structs.
module mpq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  mpq_pkg::mpq_stat_t stat,
  output mpq_pkg::mpq_ctrl_t ctrl
);
  import mpq_pkg::*;

  mpq_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ctrl.load_in = 1'b1;
          state_nxt    = S_DECODE;
        end
      end
      S_DECODE: begin
        ctrl.decode = 1'b1;
        state_nxt   = stat.need_scan ? S_SCAN : S_FINISH;
      end
      S_SCAN: begin
        ctrl.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        // hold the result until the output register frees up
        if (stat.out_free) begin
          ctrl.load_out = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/mpq_dp.sv -----
// Datapath for the min priority queue: key store, count, min scan
// and output register. Depends on mpq_pkg and mpq_ram.
module mpq_dp #(
  parameter int DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mpq_pkg::mpq_ctrl_t                ctrl,
  output mpq_pkg::mpq_stat_t                stat,
  input  logic [mpq_pkg::CMD_W-1:0]         in_command,
  input  logic signed [mpq_pkg::KEY_W-1:0]  in_key,
  input  logic                              out_tready,
  output logic                              out_valid,
  output logic signed [mpq_pkg::KEY_W-1:0]  out_min_key,
  output logic [mpq_pkg::STATUS_W-1:0]      out_status,
  output logic [mpq_pkg::CNT_OUT_W-1:0]     out_entry_count,
  output logic                              out_is_empty
);
  import mpq_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [CMD_W-1:0]        cmd_r;
  logic signed [KEY_W-1:0] key_r;
  logic [CW-1:0]           count_r, count_nxt;
  logic [IW-1:0]           iss_r;
  logic [IW-1:0]           cmp_r;
  logic signed [KEY_W-1:0] min_key_r, min_key_nxt;
  logic [IW-1:0]           min_idx_r, min_idx_nxt;
  logic signed [KEY_W-1:0] res_key_r, res_key_nxt;
  logic [STATUS_W-1:0]     res_status_r, res_status_nxt;
  logic                    out_valid_r;

  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  logic [KEY_W-1:0]  ram_wdata;
  logic [KEY_W-1:0]  ram_rdata;
  logic signed [KEY_W-1:0] rd_key;

  logic is_insert, is_remove, is_lookup, full, empty, take;

  mpq_ram #(
    .WIDTH (KEY_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (iss_r),
    .rdata (ram_rdata)
  );

  assign rd_key    = $signed(ram_rdata);
  assign is_insert = (cmd_r == CMD_INSERT);
  assign is_remove = (cmd_r == CMD_REMOVE);
  assign is_lookup = is_remove || (cmd_r == CMD_PEEK);
  assign full      = (count_r == CW'(DEPTH));
  assign empty     = (count_r == '0);

  assign stat.need_scan = is_lookup && !empty;
  assign stat.scan_last = (CW'(cmp_r) == count_r - CW'(1));
  assign stat.out_free  = !out_valid_r || out_tready;

  // first entry seeds the minimum; later ones replace it only if strictly smaller
  assign take        = (cmp_r == '0) || (rd_key < min_key_r);
  assign min_key_nxt = take ? rd_key : min_key_r;
  assign min_idx_nxt = take ? cmp_r : min_idx_r;

  always_comb begin
    ram_we         = 1'b0;
    ram_waddr      = min_idx_nxt;
    ram_wdata      = ram_rdata;
    count_nxt      = count_r;
    res_key_nxt    = res_key_r;
    res_status_nxt = res_status_r;
    if (ctrl.decode) begin
      res_key_nxt    = '0;
      res_status_nxt = STATUS_OK;
      if (is_insert) begin
        if (full) begin
          res_status_nxt = STATUS_FULL;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = count_r[IW-1:0];
          ram_wdata = key_r;
          count_nxt = count_r + CW'(1);
        end
      end else if (is_lookup && empty) begin
        res_status_nxt = STATUS_EMPTY;
      end
    end else if (ctrl.scan_step && stat.scan_last) begin
      res_key_nxt = min_key_nxt;
      // fill the hole left by the minimum with the last entry
      if (is_remove) begin
        ram_we    = 1'b1;
        count_nxt = count_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (ctrl.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_in) begin
      cmd_r <= in_command;
      key_r <= in_key;
      iss_r <= '0;
      cmp_r <= '0;
    end else begin
      if (ctrl.decode || ctrl.scan_step) begin
        iss_r <= iss_r + IW'(1);
      end
      if (ctrl.scan_step) begin
        cmp_r <= cmp_r + IW'(1);
      end
    end
    if (ctrl.scan_step) begin
      min_key_r <= min_key_nxt;
      min_idx_r <= min_idx_nxt;
    end
    res_key_r    <= res_key_nxt;
    res_status_r <= res_status_nxt;
    if (ctrl.load_out) begin
      out_min_key     <= res_key_r;
      out_status      <= res_status_r;
      out_entry_count <= CNT_OUT_W'(count_r);
      out_is_empty    <= empty;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- hw/rtl/min_priority_queue_unsorted.sv -----
// Top level of the min priority queue (unsorted key store).
// Depends on mpq_pkg, mpq_ctrl, mpq_dp and mpq_ram.
//
// Bounded min-priority queue of up to DEPTH signed 32-bit keys held in an
// unsorted RAM. Each input beat carries a command in in_tuser (insert,
// remove minimum, peek minimum) and a key in in_tdata; each request yields
// exactly one output beat with the minimum key, a status code, the entry
// count after the request and an empty flag. Insert and error cases pass
// through a decode step and a finish step to a loaded result; remove and
// peek add a scan between them that reads the N stored keys one entry per
// cycle through the key store's single read port. The finish step waits
// until the output register is free. A new request is accepted only once
// the previous one has reached the output register; that result may
// still wait there for out_tready while the next request is taken.
// A remove fills the freed slot with the last stored key, so no entries
// shift. The key store needs no clearing after reset.
module min_priority_queue_unsorted #(
  parameter int DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input beats
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [mpq_pkg::IN_TDATA_W-1:0]      in_tdata,   // [31:0] key
  input  logic [mpq_pkg::CMD_W-1:0]           in_tuser,   // [1:0] command
  // result beats
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [31:0] min_key, [33:32] status, [38:34] entry_count, [39] is_empty
  output logic [mpq_pkg::OUT_TDATA_W-1:0]     out_tdata
);
  import mpq_pkg::*;

  mpq_ctrl_t               ctrl;
  mpq_stat_t               stat;
  logic signed [KEY_W-1:0] min_key;
  logic [STATUS_W-1:0]     status;
  logic [CNT_OUT_W-1:0]    entry_count;
  logic                    is_empty;

  mpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  mpq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctrl            (ctrl),
    .stat            (stat),
    .in_command      (in_tuser),
    .in_key          ($signed(in_tdata[KEY_W-1:0])),
    .out_tready      (out_tready),
    .out_valid       (out_tvalid),
    .out_min_key     (min_key),
    .out_status      (status),
    .out_entry_count (entry_count),
    .out_is_empty    (is_empty)
  );

  // pack result fields, most significant first
  assign out_tdata = {is_empty, entry_count, status, min_key};

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for min_priority_queue_unsorted: directed table, then random traffic.
// Each result is checked against an in-bench model of the bounded min-queue.
// Depends on mpq_pkg and on the RTL of min_priority_queue_unsorted.
module testbench;
  import mpq_pkg::*;

  localparam int DEPTH = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLDOFF_CYCLES = 250;
  localparam int TAIL_CYCLES = 40;
  localparam int PHASE_ITEMS = 350;
  localparam int N_DIRECTED = 28;
  // The command encoding leaves one code free; the block must ignore it.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // Result beat layout, MSB first, matching out_tdata.
  typedef struct packed {
    logic                  is_empty;
    logic [CNT_OUT_W-1:0]  entry_count;
    logic [STATUS_W-1:0]   status;
    logic [KEY_W-1:0]      min_key;
  } result_t;

  // One row of the directed table. When fixed is set, want is the
  // result read straight off the spec; otherwise the model decides.
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [KEY_W-1:0]  key;
    logic              fixed;
    result_t           want;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata;    // [31:0] key
  logic [CMD_W-1:0] in_tuser;         // [1:0] command
  logic out_tvalid;
  logic out_tready;
  // [31:0] min_key, [33:32] status, [38:34] entry_count, [39] is_empty
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Model state: keys in insertion order, plus results still owed by the block.
  logic [KEY_W-1:0] held_keys[$];
  result_t pending_results[$];

  stim_row_t directed_rows [0:N_DIRECTED-1];
  int send_idle_pct;
  int recv_stall_pct;
  int holdoff_left;
  int error_count;
  int cycle_count;

  min_priority_queue_unsorted #(
    .DEPTH(DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic result_t result_of(logic [KEY_W-1:0] min_key,
                                        logic [STATUS_W-1:0] status, int count);
    result_t r;
    r.min_key = min_key;
    r.status = status;
    r.entry_count = count[CNT_OUT_W-1:0];
    r.is_empty = (count == 0);
    return r;
  endfunction

  function automatic stim_row_t make_row(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                                         logic fixed, result_t want);
    stim_row_t r;
    r.cmd = cmd;
    r.key = key;
    r.fixed = fixed;
    r.want = want;
    return r;
  endfunction

  // Apply one request to the model queue and return the result it owes.
  // Ties on the smallest key pick the earliest entry; the value is the same.
  function automatic result_t predict_request(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key);
    logic [KEY_W-1:0] min_key;
    logic [STATUS_W-1:0] status;
    int best;
    min_key = '0;
    status = STATUS_OK;
    best = 0;
    if (cmd == CMD_INSERT) begin
      // Full store: drop the key, report full.
      if (held_keys.size() >= DEPTH) status = STATUS_FULL;
      else held_keys = {held_keys, key};
    end else if (cmd == CMD_REMOVE || cmd == CMD_PEEK) begin
      if (held_keys.size() == 0) begin
        status = STATUS_EMPTY;
      end else begin
        for (int i = 1; i < held_keys.size(); i++)
          if ($signed(held_keys[i]) < $signed(held_keys[best])) best = i;
        min_key = held_keys[best];
        if (cmd == CMD_REMOVE) held_keys.delete(best);
      end
    end
    // Unused command code: nothing changes, status stays ok.
    return result_of(min_key, status, held_keys.size());
  endfunction

  // Offer one request; entered and left at a falling edge. Hold tvalid low
  // for random idle cycles first, then keep the beat up until it is taken.
  task automatic offer_request(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                               logic fixed, result_t want);
    result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= key;
    in_tuser <= cmd;
    do @(posedge clk); while (!in_tready);
    // Beat accepted at this edge: advance the model now, the result comes later.
    predicted = predict_request(cmd, key);
    if (fixed) predicted = want;
    pending_results = {pending_results, predicted};
    @(negedge clk);
  endtask

  // Drop tvalid and wait until every owed result has been delivered.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Random traffic in segments of 25 beats, each with its own insert share:
  // insert-heavy segments fill the store and hit the full case, remove-heavy
  // ones empty it and hit the empty case, balanced ones wander in between.
  task automatic run_random(int count);
    int insert_pct;
    int pick;
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    insert_pct = 50;
    for (int i = 0; i < count; i++) begin
      if (i % 25 == 0) begin
        case ($urandom_range(2))
          0: insert_pct = 85;
          1: insert_pct = 50;
          default: insert_pct = 15;
        endcase
      end
      pick = $urandom_range(99);
      if (pick < 3) cmd = CMD_UNUSED;
      else if (pick < 3 + insert_pct) cmd = CMD_INSERT;
      else if ($urandom_range(2) != 0) cmd = CMD_REMOVE;
      else cmd = CMD_PEEK;
      // Mix full-range keys, a narrow band that forces ties, and the extremes.
      case ($urandom_range(3))
        0, 3: key = $urandom;
        1: key = $urandom_range(8) - 4;
        default: begin
          case ($urandom_range(3))
            0: key = 32'h7FFF_FFFF;
            1: key = 32'h8000_0000;
            2: key = 32'hFFFF_FFFF;
            default: key = 32'h0000_0000;
          endcase
        end
      endcase
      offer_request(cmd, key, 1'b0, '0);
    end
  endtask

  // Result side: drive tready at the falling edge. A hold-off request from
  // the main sequence keeps tready low for a long stretch, counted here.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (holdoff_left > 0) begin
        out_tready <= 1'b0;
        holdoff_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Check every accepted result beat against the oldest owed result.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pending_results.size() == 0) begin
        $error("result beat with nothing pending: %h", out_tdata);
        error_count++;
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (got.min_key !== want.min_key) begin
          $error("min_key: expected %0d, got %0d", $signed(want.min_key),
                 $signed(got.min_key));
          error_count++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          error_count++;
        end
        if (got.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
          error_count++;
        end
        if (got.is_empty !== want.is_empty) begin
          $error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
          error_count++;
        end
      end
    end
  end

  // Watchdog: end the run as failed once cycle_count passes CYCLE_LIMIT.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL min_priority_queue_unsorted");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = CMD_INSERT;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    holdoff_left = 0;
    error_count = 0;
    cycle_count = 0;

    // Directed table: empty-queue errors, the unused code, both key extremes,
    // a fill to capacity with repeated keys near the minimum, the full case, then
    // removes that walk through the ties.
    directed_rows[0]  = make_row(CMD_PEEK,   32'h0000_0000, 1'b1,
                                 result_of(32'h0, STATUS_EMPTY, 0));
    directed_rows[1]  = make_row(CMD_REMOVE, 32'hFFFF_FFFF, 1'b1,
                                 result_of(32'h0, STATUS_EMPTY, 0));
    directed_rows[2]  = make_row(CMD_UNUSED, 32'h1234_5678, 1'b1,
                                 result_of(32'h0, STATUS_OK, 0));
    directed_rows[3]  = make_row(CMD_INSERT, 32'h7FFF_FFFF, 1'b1,
                                 result_of(32'h0, STATUS_OK, 1));
    directed_rows[4]  = make_row(CMD_INSERT, 32'h8000_0000, 1'b1,
                                 result_of(32'h0, STATUS_OK, 2));
    directed_rows[5]  = make_row(CMD_PEEK,   32'hA5A5_A5A5, 1'b1,
                                 result_of(32'h8000_0000, STATUS_OK, 2));
    directed_rows[6]  = make_row(CMD_UNUSED, 32'hFFFF_FFFF, 1'b1,
                                 result_of(32'h0, STATUS_OK, 2));
    directed_rows[7]  = make_row(CMD_REMOVE, 32'h0000_0000, 1'b1,
                                 result_of(32'h8000_0000, STATUS_OK, 1));
    directed_rows[8]  = make_row(CMD_REMOVE, 32'h0000_0000, 1'b1,
                                 result_of(32'h7FFF_FFFF, STATUS_OK, 0));
    directed_rows[9]  = make_row(CMD_INSERT, 32'h0000_0003, 1'b0, '0);
    directed_rows[10] = make_row(CMD_INSERT, 32'hFFFF_FFFB, 1'b0, '0);
    directed_rows[11] = make_row(CMD_INSERT, 32'h0000_0000, 1'b0, '0);
    directed_rows[12] = make_row(CMD_INSERT, 32'hFFFF_FFFB, 1'b0, '0);
    directed_rows[13] = make_row(CMD_INSERT, 32'h7FFF_FFFF, 1'b0, '0);
    directed_rows[14] = make_row(CMD_INSERT, 32'h8000_0001, 1'b0, '0);
    directed_rows[15] = make_row(CMD_INSERT, 32'h0000_0001, 1'b0, '0);
    directed_rows[16] = make_row(CMD_INSERT, 32'hFFFF_FFFF, 1'b0, '0);
    directed_rows[17] = make_row(CMD_INSERT, 32'h0000_002A, 1'b0, '0);
    directed_rows[18] = make_row(CMD_INSERT, 32'h8000_0001, 1'b0, '0);
    directed_rows[19] = make_row(CMD_INSERT, 32'h0000_0064, 1'b0, '0);
    directed_rows[20] = make_row(CMD_INSERT, 32'hFFFF_FF9C, 1'b0, '0);
    directed_rows[21] = make_row(CMD_INSERT, 32'h5555_AAAA, 1'b0, '0);
    directed_rows[22] = make_row(CMD_INSERT, 32'hAAAA_5555, 1'b0, '0);
    directed_rows[23] = make_row(CMD_INSERT, 32'h0000_0000, 1'b0, '0);
    directed_rows[24] = make_row(CMD_INSERT, 32'h8000_0000, 1'b0, '0);
    directed_rows[25] = make_row(CMD_INSERT, 32'hDEAD_BEEF, 1'b1,
                                 result_of(32'h0, STATUS_FULL, DEPTH));
    directed_rows[26] = make_row(CMD_REMOVE, 32'h0000_0000, 1'b0, '0);
    directed_rows[27] = make_row(CMD_REMOVE, 32'h0000_0000, 1'b0, '0);

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++)
      offer_request(directed_rows[i].cmd, directed_rows[i].key, directed_rows[i].fixed,
                    directed_rows[i].want);
    drain_results();

    // Back-pressure: stall the result side for a long stretch while beats
    // keep coming, so the output register fills and in_tready drops.
    holdoff_left = HOLDOFF_CYCLES;
    run_random(12);
    drain_results();

    // Idle phases: none, sender gaps, receiver stalls, then both.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      run_random(PHASE_ITEMS);
      // Hold the sender until the block has caught up.
      drain_results();
    end

    // Let any stray beat show up before the verdict.
    repeat (TAIL_CYCLES) @(negedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("PASS min_priority_queue_unsorted");
    end else begin
      $display("FAIL min_priority_queue_unsorted");
    end
    $finish;
  end

endmodule

// ----- min_priority_queue_unsorted.f -----
hw/rtl/mpq_pkg.sv
hw/rtl/mpq_ram.sv
hw/rtl/mpq_ctrl.sv
hw/rtl/mpq_dp.sv
hw/rtl/min_priority_queue_unsorted.sv
dv/testbench.sv
